// ===== rtl/bdpc_pkg.sv =====
// Types and constants shared by the button debounce and press classifier.
package bdpc_pkg;

  localparam int unsigned NUM_BUTTONS = 2;
  localparam int unsigned BTN_W       = $clog2(NUM_BUTTONS);
  localparam int unsigned INTEG_W     = 4;
  localparam int unsigned HELD_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [INTEG_W-1:0] INTEG_RESET  = 4'd3;
  localparam logic [HELD_W-1:0]  HELD_MAX     = 8'd255;
  localparam logic [INTEG_W-1:0] LIMIT_RESET  = 4'd10;
  localparam logic [HELD_W-1:0]  SHORT_RESET  = 8'd8;
  localparam logic [HELD_W-1:0]  LONG_RESET   = 8'd254;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 2'd2;

  typedef enum logic [1:0] {
    KIND_PRESSED       = 2'd0,
    KIND_LONG_PRESSED  = 2'd1,
    KIND_RELEASED      = 2'd2,
    KIND_LONG_RELEASED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [BTN_W-1:0] button_sel;
    logic             pin_level;
  } in_word_t;

  typedef struct packed {
    logic [BTN_W-1:0] event_button;
    kind_e            event_kind;
  } out_word_t;

  typedef struct packed {
    logic [INTEG_W-1:0] debounce_limit;
    logic [HELD_W-1:0]  short_press_count;
    logic [HELD_W-1:0]  long_press_count;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } event_t;

endpackage

// ===== rtl/bdpc_classify.sv =====
// Per-button integrator and held-tick update with event classification for one tick.
module bdpc_classify import bdpc_pkg::*; (
  input  cfg_t               cfg_i,
  input  logic               pin_level_i,
  input  logic [INTEG_W-1:0] integ_i,
  input  logic [HELD_W-1:0]  held_i,
  output logic [INTEG_W-1:0] integ_o,
  output logic [HELD_W-1:0]  held_o,
  output event_t             event_o
);

  logic [INTEG_W-1:0] integ_n;
  logic [HELD_W-1:0]  held_n;
  logic               down;
  logic               up;

  always_comb begin
    if (!pin_level_i) begin
      integ_n = (integ_i != '0) ? integ_i - INTEG_W'(1) : integ_i;
    end else if (integ_i >= cfg_i.debounce_limit) begin
      integ_n = cfg_i.debounce_limit;
    end else begin
      integ_n = integ_i + INTEG_W'(1);
    end
  end

  assign down = (integ_n == '0);
  assign held_n = (down && held_i != HELD_MAX) ? held_i + HELD_W'(1) : held_i;
  assign up = (integ_n == cfg_i.debounce_limit) && (held_n != '0);

  // release overrides press when both fire on one tick (zero limit)
  always_comb begin
    event_o = '{valid: 1'b0, kind: KIND_PRESSED};
    held_o  = held_n;
    priority if (up) begin
      event_o.valid = 1'b1;
      event_o.kind  = (held_n >= cfg_i.long_press_count) ? KIND_LONG_RELEASED
                                                         : KIND_RELEASED;
      held_o        = '0;
    end else if (down && held_n == cfg_i.short_press_count) begin
      event_o.valid = 1'b1;
      event_o.kind  = KIND_PRESSED;
    end else if (down && held_n == cfg_i.long_press_count) begin
      event_o.valid = 1'b1;
      event_o.kind  = KIND_LONG_PRESSED;
    end
  end

  assign integ_o = integ_n;

endmodule

// ===== rtl/button_debounce_press_classifier_unit.sv =====
// Button debounce and press classifier: one scan tick in, at most one press/release event out.
//
// Accepts one scan-tick word per clock cycle while in_stall_o is low and delivers an event word
// through the input register, then the result register; ticks that cause no event produce no
// output word. Each button's integrator and held-tick counter live in flip-flops and are read,
// updated and written back between the two registers as the tick moves on, so consecutive
// ticks for the same button need no spacing. Configuration is written through a plain write
// port: index 0 debounce limit, 1 short press count, 2 long press count; other indexes are
// ignored. Write it only while no word is in flight.
module button_debounce_press_classifier_unit import bdpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t               cfg_q;
  logic               s1_valid_q;
  in_word_t           s1_q;
  logic               s1_adv;
  logic               out_valid_q;
  out_word_t          out_q;
  logic [INTEG_W-1:0] integ_q [NUM_BUTTONS];
  logic [HELD_W-1:0]  held_q  [NUM_BUTTONS];
  logic [INTEG_W-1:0] integ_d;
  logic [HELD_W-1:0]  held_d;
  event_t             ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit    <= LIMIT_RESET;
      cfg_q.short_press_count <= SHORT_RESET;
      cfg_q.long_press_count  <= LONG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit    <= cfg_data_i[INTEG_W-1:0];
        REG_SHORT_PRESS:    cfg_q.short_press_count <= cfg_data_i[HELD_W-1:0];
        REG_LONG_PRESS:     cfg_q.long_press_count  <= cfg_data_i[HELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_word_i;
    end
  end

  bdpc_classify u_classify (
    .cfg_i       (cfg_q),
    .pin_level_i (s1_q.pin_level),
    .integ_i     (integ_q[s1_q.button_sel]),
    .held_i      (held_q[s1_q.button_sel]),
    .integ_o     (integ_d),
    .held_o      (held_d),
    .event_o     (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        integ_q[i] <= INTEG_RESET;
        held_q[i]  <= '0;
      end
    end else if (s1_valid_q && s1_adv) begin
      integ_q[s1_q.button_sel] <= integ_d;
      held_q[s1_q.button_sel]  <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && ev.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q && ev.valid) begin
      out_q.event_button <= s1_q.button_sel;
      out_q.event_kind   <= ev.kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // the input side only stalls while a tick waits in the input register
  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // a release event always leaves that button's held counter cleared
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv && ev.valid &&
     (ev.kind == KIND_RELEASED || ev.kind == KIND_LONG_RELEASED))
    |=> held_q[$past(s1_q.button_sel)] == '0)
    else $error("held counter not cleared on release");

  // a press event is only given with the integrator fully down
  a_press_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv && ev.valid &&
     (ev.kind == KIND_PRESSED || ev.kind == KIND_LONG_PRESSED))
    |=> integ_q[$past(s1_q.button_sel)] == '0)
    else $error("press event with integrator not at zero");

  // an event word is loaded into the result register whenever one is produced
  a_event_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv && ev.valid) |=> out_valid_o)
    else $error("event lost");

endmodule
